@@ hw/rtl/rbm_pkg.sv @@
`timescale 1ns / 1ps

package rbm_pkg;

	localparam int LABEL_W = 8;
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 12;
	localparam int SIZE_W  = 13;
	localparam int CNT_W   = 25;
	localparam int SUM_W   = 32;
	localparam int COORD_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Quotient bits per mean; every mean fits in a channel word.
	localparam int QUO_W  = CHAN_W;
	localparam int STEP_W = $clog2(QUO_W);

	localparam logic [CFG_IDX_W-1:0] REG_REGION_LABEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd1;

	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET = 13'd640;
	localparam logic [POS_W-1:0]      POS_ONES          = '1;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic               last_pixel;
	} pix_t;

	typedef struct packed {
		logic [POS_W-1:0]  left;
		logic [POS_W-1:0]  top;
		logic [POS_W-1:0]  right;
		logic [POS_W-1:0]  bottom;
		logic [SIZE_W-1:0] box_width;
		logic [SIZE_W-1:0] box_height;
		logic [CNT_W-1:0]  pixel_count;
		logic [CHAN_W-1:0] mean_red;
		logic [CHAN_W-1:0] mean_green;
		logic [CHAN_W-1:0] mean_blue;
		logic              region_empty;
	} res_t;

	// Totals of one finished frame, handed from the front to the back.
	typedef struct packed {
		logic [COORD_W-1:0] min_col;
		logic [COORD_W-1:0] min_row;
		logic [COORD_W-1:0] max_col;
		logic [COORD_W-1:0] max_row;
		logic [CNT_W-1:0]   count;
		logic [SUM_W-1:0]   sum_red;
		logic [SUM_W-1:0]   sum_green;
		logic [SUM_W-1:0]   sum_blue;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

@@ hw/rtl/rbm_front.sv @@
`timescale 1ns / 1ps

module rbm_front #(
	parameter int MAX_DIM    = 4096,
	parameter int COLOR_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  rbm_pkg::pix_t                   pix,
	input  rbm_pkg::q_stat_t                q_stat,
	output logic                            push,
	output rbm_pkg::frame_t                 push_frame
);

	localparam int CDW = $clog2(MAX_DIM);
	localparam int MW  = (CDW > rbm_pkg::POS_W) ? CDW : rbm_pkg::POS_W;
	localparam int XW  = (CDW + 1 > rbm_pkg::SIZE_W) ? CDW + 1 : rbm_pkg::SIZE_W;
	localparam logic [rbm_pkg::CHAN_W-1:0] CMASK =
		rbm_pkg::CHAN_W'((33'd1 << COLOR_BITS) - 33'd1);
	localparam logic [rbm_pkg::CNT_W-1:0] CNT_MAX = '1;

	logic [rbm_pkg::LABEL_W-1:0]    label_q;
	logic [rbm_pkg::CFG_DATA_W-1:0] width_q;

	logic [CDW-1:0] column_q, row_q;
	logic [MW-1:0]  min_col_q, min_row_q, max_col_q, max_row_q;
	logic [rbm_pkg::SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [rbm_pkg::CNT_W-1:0] count_q;

	logic [XW-1:0] w_ext, w_eff;
	logic          col_wrap, hit, take, acc;
	logic [MW-1:0] col_m, row_m;
	logic [MW-1:0] min_col_n, min_row_n, max_col_n, max_row_n;
	logic [rbm_pkg::SUM_W-1:0] sum_r_n, sum_g_n, sum_b_n;
	logic [rbm_pkg::CNT_W-1:0] count_n;
	logic [rbm_pkg::CHAN_W-1:0] r_m, g_m, b_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_q <= '0;
			width_q <= rbm_pkg::IMAGE_WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rbm_pkg::REG_REGION_LABEL: label_q <= cfg_data[rbm_pkg::LABEL_W-1:0];
				rbm_pkg::REG_IMAGE_WIDTH:  width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold a closing pixel while the queue has no room for its frame.
	assign pix_ready = !(pix.last_pixel && q_stat.full);
	assign acc       = pix_valid && pix_ready;

	always_comb begin
		w_ext = XW'(width_q);
		if (w_ext == '0)
			w_eff = XW'(1);
		else if (w_ext > XW'(MAX_DIM))
			w_eff = XW'(MAX_DIM);
		else
			w_eff = w_ext;
		col_wrap = (XW'(column_q) + XW'(1)) >= w_eff;

		r_m = pix.red & CMASK;
		g_m = pix.green & CMASK;
		b_m = pix.blue & CMASK;

		col_m = MW'(column_q);
		row_m = MW'(row_q);
		hit   = pix.label == label_q;
		take  = hit && (count_q != CNT_MAX);

		min_col_n = (hit && col_m < min_col_q) ? col_m : min_col_q;
		min_row_n = (hit && row_m < min_row_q) ? row_m : min_row_q;
		max_col_n = (hit && col_m > max_col_q) ? col_m : max_col_q;
		max_row_n = (hit && row_m > max_row_q) ? row_m : max_row_q;
		count_n   = take ? count_q + rbm_pkg::CNT_W'(1) : count_q;
		sum_r_n   = take ? rbm_pkg::sat_add(sum_r_q, r_m) : sum_r_q;
		sum_g_n   = take ? rbm_pkg::sat_add(sum_g_q, g_m) : sum_g_q;
		sum_b_n   = take ? rbm_pkg::sat_add(sum_b_q, b_m) : sum_b_q;

		push = acc && pix.last_pixel;
		push_frame.min_col   = rbm_pkg::COORD_W'(min_col_n);
		push_frame.min_row   = rbm_pkg::COORD_W'(min_row_n);
		push_frame.max_col   = rbm_pkg::COORD_W'(max_col_n);
		push_frame.max_row   = rbm_pkg::COORD_W'(max_row_n);
		push_frame.count     = count_n;
		push_frame.sum_red   = sum_r_n;
		push_frame.sum_green = sum_g_n;
		push_frame.sum_blue  = sum_b_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			min_col_q <= MW'(rbm_pkg::POS_ONES);
			min_row_q <= MW'(rbm_pkg::POS_ONES);
			max_col_q <= '0;
			max_row_q <= '0;
			sum_r_q   <= '0;
			sum_g_q   <= '0;
			sum_b_q   <= '0;
			count_q   <= '0;
		end else if (acc) begin
			if (pix.last_pixel) begin
				column_q  <= '0;
				row_q     <= '0;
				min_col_q <= MW'(rbm_pkg::POS_ONES);
				min_row_q <= MW'(rbm_pkg::POS_ONES);
				max_col_q <= '0;
				max_row_q <= '0;
				sum_r_q   <= '0;
				sum_g_q   <= '0;
				sum_b_q   <= '0;
				count_q   <= '0;
			end else begin
				min_col_q <= min_col_n;
				min_row_q <= min_row_n;
				max_col_q <= max_col_n;
				max_row_q <= max_row_n;
				sum_r_q   <= sum_r_n;
				sum_g_q   <= sum_g_n;
				sum_b_q   <= sum_b_n;
				count_q   <= count_n;
				if (col_wrap) begin
					column_q <= '0;
					if (row_q < CDW'(MAX_DIM - 1))
						row_q <= row_q + CDW'(1);
				end else begin
					column_q <= column_q + CDW'(1);
				end
			end
		end
	end

endmodule

@@ hw/rtl/rbm_queue.sv @@
`timescale 1ns / 1ps

module rbm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rbm_pkg::frame_t   push_frame,
	input  logic              pop,
	output rbm_pkg::frame_t   head,
	output rbm_pkg::q_stat_t  q_stat
);

	rbm_pkg::frame_t              mem_q [rbm_pkg::QUEUE_DEPTH];
	logic [rbm_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [rbm_pkg::QCNT_W-1:0]   fill_q;
	logic                         do_push, do_pop;

	assign q_stat.full  = fill_q == rbm_pkg::QCNT_W'(rbm_pkg::QUEUE_DEPTH);
	assign q_stat.empty = fill_q == '0;
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == rbm_pkg::QPTR_W'(rbm_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_q + rbm_pkg::QPTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == rbm_pkg::QPTR_W'(rbm_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_q + rbm_pkg::QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + rbm_pkg::QCNT_W'(1);
				2'b01:   fill_q <= fill_q - rbm_pkg::QCNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/rbm_back.sv @@
`timescale 1ns / 1ps

module rbm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rbm_pkg::frame_t   head,
	input  rbm_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output rbm_pkg::res_t     res
);

	localparam int SW = rbm_pkg::SUM_W;

	rbm_pkg::back_state_t state_q, state_n;

	rbm_pkg::res_t              work_q, res_q;
	rbm_pkg::res_t              work_n, res_n;
	logic                       res_valid_q;
	logic [SW-1:0]              rem_r_q, rem_g_q, rem_b_q, div_q;
	logic [rbm_pkg::QUO_W-1:0]  quo_r_q, quo_g_q, quo_b_q;
	logic [rbm_pkg::STEP_W-1:0] step_q;

	logic          out_free, do_step, load_out, head_empty, last_step;
	logic [SW:0]   dif_r, dif_g, dif_b;

	assign out_free   = !res_valid_q || res_ready;
	assign head_empty = head.count == '0;
	assign last_step  = step_q == rbm_pkg::STEP_W'(rbm_pkg::QUO_W - 1);

	always_comb begin
		state_n = state_q;
		case (state_q)
			rbm_pkg::BK_IDLE:
				if (!q_stat.empty)
					state_n = head_empty ? rbm_pkg::BK_DONE : rbm_pkg::BK_DIV;
			rbm_pkg::BK_DIV:
				if (last_step)
					state_n = rbm_pkg::BK_DONE;
			rbm_pkg::BK_DONE:
				if (out_free)
					state_n = rbm_pkg::BK_IDLE;
			default: state_n = rbm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		do_step  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rbm_pkg::BK_IDLE: pop      = !q_stat.empty;
			rbm_pkg::BK_DIV:  do_step  = 1'b1;
			rbm_pkg::BK_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rbm_pkg::BK_IDLE;
		else
			state_q <= state_n;
	end

	// Box fields of the frame at the queue head; means follow from the divider.
	always_comb begin
		work_n = '0;
		if (head_empty) begin
			work_n.region_empty = 1'b1;
		end else begin
			work_n.left        = head.min_col[rbm_pkg::POS_W-1:0];
			work_n.top         = head.min_row[rbm_pkg::POS_W-1:0];
			work_n.right       = head.max_col[rbm_pkg::POS_W-1:0];
			work_n.bottom      = head.max_row[rbm_pkg::POS_W-1:0];
			work_n.box_width   = rbm_pkg::SIZE_W'(head.max_col - head.min_col
				+ rbm_pkg::COORD_W'(1));
			work_n.box_height  = rbm_pkg::SIZE_W'(head.max_row - head.min_row
				+ rbm_pkg::COORD_W'(1));
			work_n.pixel_count = head.count;
		end

		res_n            = work_q;
		res_n.mean_red   = quo_r_q;
		res_n.mean_green = quo_g_q;
		res_n.mean_blue  = quo_b_q;
	end

	// Restoring division, one quotient bit per cycle for all three channels.
	assign dif_r = {1'b0, rem_r_q} - {1'b0, div_q};
	assign dif_g = {1'b0, rem_g_q} - {1'b0, div_q};
	assign dif_b = {1'b0, rem_b_q} - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (pop) begin
			step_q  <= '0;
			quo_r_q <= '0;
			quo_g_q <= '0;
			quo_b_q <= '0;
			rem_r_q <= head.sum_red;
			rem_g_q <= head.sum_green;
			rem_b_q <= head.sum_blue;
			div_q   <= SW'({head.count, {(rbm_pkg::QUO_W-1){1'b0}}});
			work_q  <= work_n;
		end else if (do_step) begin
			step_q  <= step_q + rbm_pkg::STEP_W'(1);
			div_q   <= div_q >> 1;
			quo_r_q <= {quo_r_q[rbm_pkg::QUO_W-2:0], !dif_r[SW]};
			quo_g_q <= {quo_g_q[rbm_pkg::QUO_W-2:0], !dif_g[SW]};
			quo_b_q <= {quo_b_q[rbm_pkg::QUO_W-2:0], !dif_b[SW]};
			if (!dif_r[SW])
				rem_r_q <= dif_r[SW-1:0];
			if (!dif_g[SW])
				rem_g_q <= dif_g[SW-1:0];
			if (!dif_b[SW])
				rem_b_q <= dif_b[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_out)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ hw/rtl/region_bbox_mean_color.sv @@
`timescale 1ns / 1ps

// Channel   Signals                            Direction  Transaction
// pix       pix_valid, pix_ready, pix          in         one pixel, raster order
// res       res_valid, res_ready, res          out        one frame summary
// cfg       cfg_we, cfg_index, cfg_data        in         register write, no wait
//
// Each accepted pixel is folded into the front accumulator.
// A frame summary leaves the queue, passes through the shared restoring
// divider (one quotient bit per step) and is loaded into the output register
// once that register is free; an empty region skips the divider.
// A two-entry frame queue lets the front keep taking pixels while the divider
// runs; only a last pixel stalls, and only when the queue is full.
// Reset clears the accumulators, queue and output valid; no clearing pass.

module region_bbox_mean_color #(
	parameter int MAX_DIM    = 4096,
	parameter int COLOR_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  rbm_pkg::pix_t                   pix,
	output logic                            res_valid,
	input  logic                            res_ready,
	output rbm_pkg::res_t                   res
);

	rbm_pkg::q_stat_t q_stat;
	rbm_pkg::frame_t  push_frame, head;
	logic             push, pop;

	rbm_front #(
		.MAX_DIM    (MAX_DIM),
		.COLOR_BITS (COLOR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	rbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	rbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ tb/tb_region_bbox_mean_color.sv @@
`timescale 1ns / 1ps

module tb_region_bbox_mean_color;

	localparam int MAX_DIM       = 4096;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PIXELS = 1300;
	localparam int MAX_WAIT      = 12;
	localparam int REPORT_LIMIT  = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           pix_valid;
	logic                           pix_ready;
	rbm_pkg::pix_t                  pix;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	rbm_pkg::res_t                  res;

	region_bbox_mean_color u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Shadow registers and frame accumulators of the predictor
	logic [rbm_pkg::LABEL_W-1:0]    want_label;
	logic [rbm_pkg::CFG_DATA_W-1:0] width_reg;
	logic [rbm_pkg::POS_W-1:0]      cur_col, cur_row;
	logic [rbm_pkg::POS_W-1:0]      lo_col, lo_row, hi_col, hi_row;
	logic [rbm_pkg::SUM_W-1:0]      red_total, green_total, blue_total;
	logic [rbm_pkg::CNT_W-1:0]      hit_count;
	rbm_pkg::res_t                  pending_summaries[$];

	int errors         = 0;
	int pixels_sent    = 0;
	int frames_checked = 0;
	int empty_frames   = 0;
	int reg_writes     = 0;
	int cycles         = 0;
	int ready_hold     = 0;
	bit quiet_mode     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d summaries outstanding", cycles,
				pending_summaries.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic void clear_accumulators();
		cur_col     = '0;
		cur_row     = '0;
		lo_col      = '1;
		lo_row      = '1;
		hi_col      = '0;
		hi_row      = '0;
		red_total   = '0;
		green_total = '0;
		blue_total  = '0;
		hit_count   = '0;
	endfunction

	function automatic logic [rbm_pkg::SUM_W-1:0] add_capped(
			input logic [rbm_pkg::SUM_W-1:0] acc, input logic [rbm_pkg::CHAN_W-1:0] val);
		if ({rbm_pkg::SUM_W{1'b1}} - acc < rbm_pkg::SUM_W'(val))
			return '1;
		return acc + rbm_pkg::SUM_W'(val);
	endfunction

	// Fold one accepted pixel into the frame totals; queue a summary on the last one.
	function automatic void accumulate_pixel(input rbm_pkg::pix_t p);
		int            cols;
		rbm_pkg::res_t s;
		cols = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : int'(width_reg);
		if (p.label == want_label) begin
			if (cur_col < lo_col) lo_col = cur_col;
			if (cur_row < lo_row) lo_row = cur_row;
			if (cur_col > hi_col) hi_col = cur_col;
			if (cur_row > hi_row) hi_row = cur_row;
			if (hit_count != '1) begin
				hit_count++;
				red_total   = add_capped(red_total, p.red);
				green_total = add_capped(green_total, p.green);
				blue_total  = add_capped(blue_total, p.blue);
			end
		end
		if (int'(cur_col) + 1 >= cols) begin
			cur_col = '0;
			if (cur_row != '1) cur_row++;
		end else begin
			cur_col++;
		end
		if (p.last_pixel) begin
			s = '0;
			if (hit_count == 0) begin
				s.region_empty = 1'b1;
			end else begin
				s.left        = lo_col;
				s.top         = lo_row;
				s.right       = hi_col;
				s.bottom      = hi_row;
				s.box_width   = {1'b0, hi_col} - {1'b0, lo_col} + rbm_pkg::SIZE_W'(1);
				s.box_height  = {1'b0, hi_row} - {1'b0, lo_row} + rbm_pkg::SIZE_W'(1);
				s.pixel_count = hit_count;
				s.mean_red    = rbm_pkg::CHAN_W'(red_total / rbm_pkg::SUM_W'(hit_count));
				s.mean_green  = rbm_pkg::CHAN_W'(green_total / rbm_pkg::SUM_W'(hit_count));
				s.mean_blue   = rbm_pkg::CHAN_W'(blue_total / rbm_pkg::SUM_W'(hit_count));
			end
			pending_summaries.push_back(s);
			clear_accumulators();
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("summary %0d: %s expected %0d, got %0d", frames_checked, name,
					want, got);
		end
	endfunction

	function automatic void compare_summary(input rbm_pkg::res_t want,
			input rbm_pkg::res_t got);
		frames_checked++;
		if (want.region_empty) empty_frames++;
		check_field("left", want.left, got.left);
		check_field("top", want.top, got.top);
		check_field("right", want.right, got.right);
		check_field("bottom", want.bottom, got.bottom);
		check_field("box_width", want.box_width, got.box_width);
		check_field("box_height", want.box_height, got.box_height);
		check_field("pixel_count", want.pixel_count, got.pixel_count);
		check_field("mean_red", want.mean_red, got.mean_red);
		check_field("mean_green", want.mean_green, got.mean_green);
		check_field("mean_blue", want.mean_blue, got.mean_blue);
		check_field("region_empty", want.region_empty, got.region_empty);
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_summaries.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("summary with no frame closed: %p", res);
			end else begin
				compare_summary(pending_summaries.pop_front(), res);
			end
			ready_hold = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
		end
	end

	// Hold ready low for the drawn stall after each transaction
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			res_ready <= 1'b0;
			ready_hold--;
		end else begin
			res_ready <= 1'b1;
		end
	end

	function automatic rbm_pkg::pix_t make_pixel(input int lab, input int r, input int g,
			input int b, input bit last);
		rbm_pkg::pix_t p;
		p.label      = rbm_pkg::LABEL_W'(lab);
		p.red        = rbm_pkg::CHAN_W'(r);
		p.green      = rbm_pkg::CHAN_W'(g);
		p.blue       = rbm_pkg::CHAN_W'(b);
		p.last_pixel = last;
		return p;
	endfunction

	function automatic int channel_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays up across back-to-back pixels.
	task automatic send_pixel(input rbm_pkg::pix_t p);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		accumulate_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		while (pending_summaries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rbm_pkg::CFG_IDX_W-1:0] idx, input int val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= rbm_pkg::CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rbm_pkg::REG_REGION_LABEL)
			want_label = rbm_pkg::LABEL_W'(val);
		else
			width_reg = rbm_pkg::CFG_DATA_W'(val);
		reg_writes++;
	endtask

	task automatic test_reset_values();
		send_pixel(make_pixel(0, 255, 255, 255, 0));
		send_pixel(make_pixel(7, 1, 2, 3, 0));
		send_pixel(make_pixel(0, 0, 0, 0, 0));
		send_pixel(make_pixel(0, 128, 64, 1, 1));
		// no pixel carries label 0: empty region
		send_pixel(make_pixel(1, 9, 9, 9, 0));
		send_pixel(make_pixel(255, 255, 0, 255, 1));
	endtask

	task automatic test_label_extremes();
		write_reg(rbm_pkg::REG_REGION_LABEL, 255);
		write_reg(rbm_pkg::REG_IMAGE_WIDTH, 3);
		for (int i = 0; i < 9; i++)
			send_pixel(make_pixel((i == 1 || i == 6 || i == 8) ? 255 : (i == 3 ? 0 : 254),
				(i & 1) ? 255 : 0, (i & 2) ? 255 : 0, 255 - i, i == 8));
		send_pixel(make_pixel(255, 255, 255, 255, 1));
		send_pixel(make_pixel(0, 0, 0, 0, 1));
	endtask

	task automatic test_width_limits();
		// zero counts as one column
		write_reg(rbm_pkg::REG_IMAGE_WIDTH, 0);
		for (int i = 0; i < 4; i++)
			send_pixel(make_pixel(255, 10 * i, 20 * i, 30 * i, i == 3));
		write_reg(rbm_pkg::REG_IMAGE_WIDTH, 8191);
		for (int i = 0; i < 3; i++)
			send_pixel(make_pixel(i == 0 ? 12 : 255, 200, 100, 50, i == 2));
		write_reg(rbm_pkg::REG_IMAGE_WIDTH, MAX_DIM + 1);
		send_pixel(make_pixel(255, 1, 1, 1, 0));
		send_pixel(make_pixel(255, 2, 2, 2, 1));
	endtask

	task automatic test_random_frames();
		int                          start_count;
		int                          frame_len;
		int                          hit_pct;
		int                          w;
		logic [rbm_pkg::LABEL_W-1:0] lab;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			case ($urandom_range(0, 7))
				0: w = 0;
				1: w = 1;
				2: w = MAX_DIM;
				3: w = $urandom_range(MAX_DIM + 1, 8191);
				default: w = $urandom_range(2, 16);
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(rbm_pkg::REG_REGION_LABEL, 0);
				1: write_reg(rbm_pkg::REG_REGION_LABEL, 255);
				default: write_reg(rbm_pkg::REG_REGION_LABEL, $urandom_range(0, 255));
			endcase
			write_reg(rbm_pkg::REG_IMAGE_WIDTH, w);
			quiet_mode = ($urandom_range(0, 3) == 0);
			hit_pct = $urandom_range(0, 100);
			repeat ($urandom_range(1, 6)) begin
				frame_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40);
				for (int i = 0; i < frame_len; i++) begin
					lab = ($urandom_range(0, 99) < hit_pct) ? want_label
						: rbm_pkg::LABEL_W'($urandom_range(0, 255));
					send_pixel(make_pixel(lab, channel_value(), channel_value(),
						channel_value(), i == frame_len - 1));
				end
			end
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		pix_valid  = 1'b0;
		pix        = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		want_label = '0;
		width_reg  = rbm_pkg::IMAGE_WIDTH_RESET;
		clear_accumulators();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_label_extremes();
		test_width_limits();
		test_random_frames();
		drain();

		$display("Checked %0d frame summaries (%0d with an empty region) from %0d pixels",
			frames_checked, empty_frames, pixels_sent);
		$display("%0d register writes, %0d mismatches", reg_writes, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ region_bbox_mean_color.f @@
hw/rtl/rbm_pkg.sv
hw/rtl/rbm_front.sv
hw/rtl/rbm_queue.sv
hw/rtl/rbm_back.sv
hw/rtl/region_bbox_mean_color.sv
tb/tb_region_bbox_mean_color.sv
